[rtl/core/gbts_pkg.sv]
// shared types and constants of the gap buffer text store
package gbts_pkg;

  localparam int unsigned BYTE_W   = 8;
  localparam int unsigned FIELD_W  = 13;
  localparam int unsigned S_USER_W = 3;
  localparam int unsigned M_USER_W = 2;
  localparam int unsigned TDATA_W  = 40;
  localparam int unsigned TPAD_W   = TDATA_W - BYTE_W - 2 * FIELD_W;

  typedef enum logic [S_USER_W-1:0] {
    REQ_INSERT = 3'd0,
    REQ_DELETE = 3'd1,
    REQ_MOVE   = 3'd2,
    REQ_REMOVE = 3'd3,
    REQ_READ   = 3'd4
  } req_e;

  typedef enum logic [M_USER_W-1:0] {
    STATUS_OK        = 2'd0,
    STATUS_FULL      = 2'd1,
    STATUS_READ_PAST = 2'd2
  } status_e;

  typedef struct packed {
    req_e               req_type;
    logic [BYTE_W-1:0]  data_byte;
    logic [FIELD_W-1:0] position;
    logic [FIELD_W-1:0] count;
    logic               run_last;
  } req_t;

  typedef struct packed {
    logic [BYTE_W-1:0]  read_data;
    logic [FIELD_W-1:0] cursor;
    logic [FIELD_W-1:0] text_length;
    status_e            status;
    logic               run_done;
  } res_t;

endpackage

[rtl/core/gap_buffer_text_store.sv]
// top level of the gap buffer text store with stream ports and output register
// Gap buffer holding up to DEPTH text bytes in one byte ram, with the gap kept
// at the cursor. Each request gives one result carrying cursor and length.
// Insert, delete, read and unknown requests go from the transfer straight to
// the result. Move and remove range alternate read and write states while the
// cursor travels: every byte crossing the gap is one ram read followed by
// one ram write. A new request is taken once the previous result has left the
// sequencer; the output register lets it wait there for the downstream side.
// No clearing pass after reset: the store is only read where text was written.
module gap_buffer_text_store
  import gbts_pkg::*;
#(
  parameter int unsigned DEPTH = 4096
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                s_axis_tvalid,
  output logic                s_axis_tready,
  // data_byte[7:0], position[20:8], count[33:21], zero fill
  input  logic [TDATA_W-1:0]  s_axis_tdata,
  // req_type[2:0]
  input  logic [S_USER_W-1:0] s_axis_tuser,
  input  logic                s_axis_tlast,
  output logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  // read_data[7:0], cursor[20:8], text_length[33:21], zero fill
  output logic [TDATA_W-1:0]  m_axis_tdata,
  // status[1:0]
  output logic [M_USER_W-1:0] m_axis_tuser,
  output logic                m_axis_tlast
);

  localparam int unsigned AW = $clog2(DEPTH);

  req_t              req;
  res_t              res;
  res_t              out_q;
  logic              out_valid_q;
  logic              res_valid;
  logic              res_ready;
  logic              ram_we, ram_re;
  logic [AW-1:0]     ram_waddr, ram_raddr;
  logic [BYTE_W-1:0] ram_wdata, ram_rdata;

  always_comb begin
    req.req_type  = req_e'(s_axis_tuser);
    req.data_byte = s_axis_tdata[BYTE_W-1:0];
    req.position  = s_axis_tdata[BYTE_W+FIELD_W-1:BYTE_W];
    req.count     = s_axis_tdata[BYTE_W+2*FIELD_W-1:BYTE_W+FIELD_W];
    req.run_last  = s_axis_tlast;
  end

  gbts_ctrl #(
    .DEPTH (DEPTH)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_valid_i (s_axis_tvalid),
    .req_ready_o (s_axis_tready),
    .req_i       (req),
    .res_valid_o (res_valid),
    .res_ready_i (res_ready),
    .res_o       (res),
    .ram_we_o    (ram_we),
    .ram_waddr_o (ram_waddr),
    .ram_wdata_o (ram_wdata),
    .ram_re_o    (ram_re),
    .ram_raddr_o (ram_raddr),
    .ram_rdata_i (ram_rdata)
  );

  gbts_ram #(
    .WIDTH (BYTE_W),
    .DEPTH (DEPTH)
  ) u_text_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  assign res_ready = !out_valid_q || m_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (res_ready) begin
      out_valid_q <= res_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_ready && res_valid) begin
      out_q <= res;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {TPAD_W'(0), out_q.text_length, out_q.cursor, out_q.read_data};
  assign m_axis_tuser  = out_q.status;
  assign m_axis_tlast  = out_q.run_done;

endmodule

[rtl/core/gbts_ram.sv]
// generic single-write single-read ram with registered read data
module gbts_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 4096
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

[rtl/core/gbts_ctrl.sv]
// request sequencer: gap pointers, clamping and byte shifting across the gap
module gbts_ctrl
  import gbts_pkg::*;
#(
  parameter int unsigned DEPTH = 4096
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     req_valid_i,
  output logic                     req_ready_o,
  input  req_t                     req_i,
  output logic                     res_valid_o,
  input  logic                     res_ready_i,
  output res_t                     res_o,
  output logic                     ram_we_o,
  output logic [$clog2(DEPTH)-1:0] ram_waddr_o,
  output logic [BYTE_W-1:0]        ram_wdata_o,
  output logic                     ram_re_o,
  output logic [$clog2(DEPTH)-1:0] ram_raddr_o,
  input  logic [BYTE_W-1:0]        ram_rdata_i
);

  localparam int unsigned AW = $clog2(DEPTH);
  localparam int unsigned PW = AW + 1;
  localparam int unsigned CW = (PW > FIELD_W) ? PW : FIELD_W;
  localparam logic [PW-1:0] DEPTH_P = PW'(DEPTH);
  localparam logic [PW-1:0] ONE_P = PW'(1);

  typedef enum logic [3:0] {
    ST_IDLE  = 4'b0001,
    ST_MV_RD = 4'b0010,
    ST_MV_WR = 4'b0100,
    ST_RESP  = 4'b1000
  } state_e;

  state_e          state_q, state_d;
  logic [PW-1:0]   gs_q, gs_d;
  logic [PW-1:0]   ge_q, ge_d;
  req_e            op_q, op_d;
  logic [PW-1:0]   tgt_q, tgt_d;
  logic [PW-1:0]   cnt_q, cnt_d;
  logic            last_q, last_d;
  status_e         status_q, status_d;
  logic            rd_ok_q, rd_ok_d;

  logic [PW-1:0]   len;
  logic [CW-1:0]   len_c, pos_c, cnt_c, gs_c, cur_c, len_out_c;
  logic [PW-1:0]   pos_clamp, rem_avail, cnt_clamp, del_amt;
  logic [PW-1:0]   pos_p, rd_addr, gs_dec, ge_dec;
  logic            accept;

  assign len       = DEPTH_P - (ge_q - gs_q);
  assign len_c     = CW'(len);
  assign pos_c     = CW'(req_i.position);
  assign cnt_c     = CW'(req_i.count);
  assign gs_c      = CW'(gs_q);
  assign pos_p     = pos_c[PW-1:0];
  assign pos_clamp = (pos_c > len_c) ? len : pos_p;
  assign rem_avail = len - pos_clamp;
  assign cnt_clamp = (cnt_c > CW'(rem_avail)) ? rem_avail : cnt_c[PW-1:0];
  assign del_amt   = (cnt_c > gs_c) ? gs_q : cnt_c[PW-1:0];
  assign rd_addr   = (pos_p < gs_q) ? pos_p : ge_q + (pos_p - gs_q);
  assign gs_dec    = gs_q - ONE_P;
  assign ge_dec    = ge_q - ONE_P;
  assign accept    = req_valid_i && req_ready_o;

  assign req_ready_o = (state_q == ST_IDLE);
  assign res_valid_o = (state_q == ST_RESP);

  always_comb begin
    state_d     = state_q;
    gs_d        = gs_q;
    ge_d        = ge_q;
    op_d        = op_q;
    tgt_d       = tgt_q;
    cnt_d       = cnt_q;
    last_d      = last_q;
    status_d    = status_q;
    rd_ok_d     = rd_ok_q;
    ram_we_o    = 1'b0;
    ram_waddr_o = gs_q[AW-1:0];
    ram_wdata_o = req_i.data_byte;
    ram_re_o    = 1'b0;
    ram_raddr_o = rd_addr[AW-1:0];
    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          op_d     = req_i.req_type;
          last_d   = req_i.run_last;
          status_d = STATUS_OK;
          rd_ok_d  = 1'b0;
          tgt_d    = pos_clamp;
          cnt_d    = cnt_clamp;
          state_d  = ST_RESP;
          unique case (req_i.req_type)
            REQ_INSERT: begin
              if (gs_q < ge_q) begin
                ram_we_o = 1'b1;
                gs_d     = gs_q + ONE_P;
              end else begin
                status_d = STATUS_FULL;
              end
            end
            REQ_DELETE: gs_d = gs_q - del_amt;
            REQ_MOVE,
            REQ_REMOVE: state_d = ST_MV_RD;
            REQ_READ: begin
              if (pos_c < len_c) begin
                ram_re_o = 1'b1;
                rd_ok_d  = 1'b1;
              end else begin
                status_d = STATUS_READ_PAST;
              end
            end
            default: ;
          endcase
        end
      end
      ST_MV_RD: begin
        if (tgt_q == gs_q) begin
          if (op_q == REQ_REMOVE) begin
            ge_d = ge_q + cnt_q;
          end
          state_d = ST_RESP;
        end else begin
          ram_re_o    = 1'b1;
          ram_raddr_o = (tgt_q < gs_q) ? gs_dec[AW-1:0] : ge_q[AW-1:0];
          state_d     = ST_MV_WR;
        end
      end
      ST_MV_WR: begin
        ram_we_o    = 1'b1;
        ram_wdata_o = ram_rdata_i;
        if (tgt_q < gs_q) begin
          ram_waddr_o = ge_dec[AW-1:0];
          gs_d        = gs_dec;
          ge_d        = ge_dec;
        end else begin
          ram_waddr_o = gs_q[AW-1:0];
          gs_d        = gs_q + ONE_P;
          ge_d        = ge_q + ONE_P;
        end
        state_d = ST_MV_RD;
      end
      ST_RESP: begin
        if (res_ready_i) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      gs_q    <= '0;
      ge_q    <= DEPTH_P;
    end else begin
      state_q <= state_d;
      gs_q    <= gs_d;
      ge_q    <= ge_d;
    end
  end

  always_ff @(posedge clk_i) begin
    op_q     <= op_d;
    tgt_q    <= tgt_d;
    cnt_q    <= cnt_d;
    last_q   <= last_d;
    status_q <= status_d;
    rd_ok_q  <= rd_ok_d;
  end

  assign cur_c     = CW'(gs_q);
  assign len_out_c = CW'(len);

  always_comb begin
    res_o.read_data   = rd_ok_q ? ram_rdata_i : '0;
    res_o.cursor      = cur_c[FIELD_W-1:0];
    res_o.text_length = len_out_c[FIELD_W-1:0];
    res_o.status      = status_q;
    res_o.run_done    = last_q;
  end

endmodule

[rtl/core/gbts_checker.sv]
// port-level checks of the gap buffer text store and their binding
module gbts_checker
  import gbts_pkg::*;
#(
  parameter int unsigned DEPTH = 4096
) (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                s_axis_tvalid,
  input logic                s_axis_tready,
  input logic [TDATA_W-1:0]  s_axis_tdata,
  input logic [S_USER_W-1:0] s_axis_tuser,
  input logic                s_axis_tlast,
  input logic                m_axis_tvalid,
  input logic                m_axis_tready,
  input logic [TDATA_W-1:0]  m_axis_tdata,
  input logic [M_USER_W-1:0] m_axis_tuser,
  input logic                m_axis_tlast
);

  localparam logic [FIELD_W-1:0] FULL_LEN = FIELD_W'(DEPTH);

  logic [BYTE_W-1:0]  out_byte;
  logic [FIELD_W-1:0] out_len;

  assign out_byte   = m_axis_tdata[BYTE_W-1:0];
  assign out_len    = m_axis_tdata[BYTE_W+2*FIELD_W-1:BYTE_W+FIELD_W];

  // stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser)
      && $stable(m_axis_tlast))
    else $error("result changed while stalled");

  // dropped byte only when the gap is empty
  a_full_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && (m_axis_tuser == STATUS_FULL) |-> (out_len == FULL_LEN))
    else $error("full status with free space");

  // failed read returns zero
  a_past_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && (m_axis_tuser == STATUS_READ_PAST) |-> (out_byte == '0))
    else $error("read past text with nonzero data");

  // status code in range
  a_status_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |->
      (m_axis_tuser == STATUS_OK) || (m_axis_tuser == STATUS_FULL)
      || (m_axis_tuser == STATUS_READ_PAST))
    else $error("unknown status code");

endmodule

bind gap_buffer_text_store gbts_checker #(.DEPTH(DEPTH)) u_gbts_checker (.*);
